// ===== hw/rtl/modbus_read_reply_checker_top_assert.svh =====
// assertion macros shared by the checker rtl
`ifndef MODBUS_READ_REPLY_CHECKER_TOP_ASSERT_SVH
`define MODBUS_READ_REPLY_CHECKER_TOP_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define MRRC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next
`define MRRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mrrc_pkg.sv =====
`timescale 1ns / 1ps

package mrrc_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_SLAVE    = 2'd0;
	localparam logic [1:0] REG_FUNCTION = 2'd1;
	localparam logic [1:0] REG_WCOUNT   = 2'd2;

	// result kinds
	localparam logic KIND_WORD   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// frame status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_MALFORMED = 3'd1;
	localparam logic [2:0] ST_CRC       = 3'd2;
	localparam logic [2:0] ST_SLAVE     = 3'd3;
	localparam logic [2:0] ST_EXCEPTION = 3'd4;
	localparam logic [2:0] ST_FUNCTION  = 3'd5;
	localparam logic [2:0] ST_BYTECOUNT = 3'd6;

	localparam logic [7:0]  EXC_FLAG   = 8'h80;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam int          MIN_FRAME  = 5;
	localparam int          HEADER_LEN = 5;

	typedef struct packed {
		logic [7:0] slave;
		logic [2:0] fcode;
		logic [6:0] wcount;
	} cfg_t;

	// captured header and trailer view of the frame for the status check
	typedef struct packed {
		logic [7:0]  address;
		logic [7:0]  fcode;
		logic [7:0]  third;
		logic [15:0] crc;
		logic [15:0] delayed;
	} frame_view_t;

	typedef struct packed {
		logic        kind;
		logic [6:0]  word_index;
		logic [15:0] word_value;
		logic [2:0]  status;
		logic [7:0]  exc_code;
	} res_t;

	// one byte of crc-16/modbus, reflected, lsb first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/mrrc_if.sv =====
`timescale 1ns / 1ps

// received byte channel
interface mrrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_last;

	modport source(output valid, rx_byte, frame_last, input ready);
	modport sink(input valid, rx_byte, frame_last, output ready);
endinterface

// word and status result channel
interface mrrc_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [6:0]  word_index;
	logic [15:0] word_value;
	logic [2:0]  status;
	logic [7:0]  exc_code;

	modport source(output valid, result_kind, word_index, word_value, status,
		exc_code, input ready);
	modport sink(input valid, result_kind, word_index, word_value, status,
		exc_code, output ready);
endinterface

// ===== hw/rtl/modbus_read_reply_checker_top.sv =====
`timescale 1ns / 1ps

// channel   dir   payload                                            handshake
// in_ch     in    rx_byte[7:0], frame_last                           valid/ready
// out_ch    out   result_kind, word_index[6:0], word_value[15:0],    valid/ready
//                 status[2:0], exc_code[7:0]
// cfg       in    cfg_we, cfg_idx[1:0], cfg_data[7:0]                write only
//
// one byte per cycle sustained while out_ch takes results; the byte-wide crc update
// and the status compares sit between the input register and the result register.
// a result is loaded into the result register when its byte leaves the input register.
// reset clears the frame state; crc starts at 0xFFFF and the config regs
// take slave 1, function 3, word count 1.
// a byte that makes no result drains even while out_ch stalls; a byte that makes
// a result waits in the input register until the result register frees up.

module modbus_read_reply_checker_top
	import mrrc_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 255,
	parameter int MAX_WORDS       = 125
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_data,
	mrrc_in_if.sink    in_ch,
	mrrc_out_if.source out_ch
);

	`include "modbus_read_reply_checker_top_assert.svh"

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_valid_q;
	res_t       out_q;

	logic       accept_in;
	logic       out_free;
	logic       advance;
	logic       has_res;
	res_t       res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{slave: 8'd1, fcode: 3'd3, wcount: 7'd1};
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SLAVE:    cfg_q.slave  <= cfg_data;
				REG_FUNCTION: cfg_q.fcode  <= cfg_data[2:0];
				REG_WCOUNT:   cfg_q.wcount <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign accept_in   = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign advance     = valid_s1 && (!has_res || out_free);
	assign in_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			byte_s1 <= in_ch.rx_byte;
			last_s1 <= in_ch.frame_last;
		end
	end

	mrrc_frame_core #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES),
		.MAX_WORDS(MAX_WORDS),
		.CNT_W(CNT_W)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.rx_byte(byte_s1),
		.frame_last(last_s1),
		.advance(advance),
		.has_res(has_res),
		.res(res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			out_q <= res;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.result_kind = out_q.kind;
	assign out_ch.word_index  = out_q.word_index;
	assign out_ch.word_value  = out_q.word_value;
	assign out_ch.status      = out_q.status;
	assign out_ch.exc_code    = out_q.exc_code;

	`MRRC_ASSERT_NEXT(a_s1_held, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(byte_s1) && $stable(last_s1), "stalled input item lost")
	`MRRC_ASSERT_CLK(a_word_clean, clk, arst_n, (out_valid_q && out_q.kind == KIND_WORD) |-> (out_q.status == ST_OK && out_q.exc_code == 8'd0), "word result carries status fields")
	`MRRC_ASSERT_CLK(a_exc_code, clk, arst_n, (out_valid_q && out_q.exc_code != 8'd0) |-> (out_q.status == ST_EXCEPTION), "exception code without exception status")

endmodule

// ===== hw/rtl/mrrc_status_eval.sv =====
`timescale 1ns / 1ps

module mrrc_status_eval
	import mrrc_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 255,
	parameter int MAX_WORDS       = 125,
	parameter int CNT_W           = 9
) (
	input  cfg_t             cfg,
	input  frame_view_t      view,
	input  logic [CNT_W-1:0] length,
	output logic [2:0]       status,
	output logic [7:0]       exc_code
);

	localparam int LEN_W = (CNT_W > 9) ? CNT_W : 9;

	logic             count_ok;
	logic             len_bad;
	logic             crc_bad;
	logic [LEN_W-1:0] len_ext;
	logic [LEN_W-1:0] exp_len;
	logic [8:0]       exp_bytes;

	assign count_ok  = (cfg.wcount != 7'd0) && (cfg.wcount <= 7'(MAX_WORDS));
	assign len_ext   = LEN_W'(length);
	assign exp_bytes = {1'b0, cfg.wcount, 1'b0};
	assign exp_len   = LEN_W'(exp_bytes) + LEN_W'(HEADER_LEN);
	assign len_bad   = (len_ext < LEN_W'(MIN_FRAME)) ||
		(len_ext > LEN_W'(MAX_FRAME_BYTES)) || !count_ok;
	// trailer carries the crc low byte first
	assign crc_bad   = (view.delayed[15:8] != view.crc[7:0]) ||
		(view.delayed[7:0] != view.crc[15:8]);

	// checks in priority order
	always_comb begin
		status   = ST_OK;
		exc_code = 8'd0;
		if (len_bad) begin
			status = ST_MALFORMED;
		end else if (crc_bad) begin
			status = ST_CRC;
		end else if (view.address != cfg.slave) begin
			status = ST_SLAVE;
		end else if (view.fcode == ({5'd0, cfg.fcode} | EXC_FLAG)) begin
			if (len_ext == LEN_W'(HEADER_LEN)) begin
				status   = ST_EXCEPTION;
				exc_code = view.third;
			end else begin
				status = ST_MALFORMED;
			end
		end else if (view.fcode != {5'd0, cfg.fcode}) begin
			status = ST_FUNCTION;
		end else if ({1'b0, view.third} != exp_bytes) begin
			status = ST_BYTECOUNT;
		end else if (len_ext != exp_len) begin
			status = ST_MALFORMED;
		end
	end

endmodule

// ===== hw/rtl/mrrc_frame_core.sv =====
`timescale 1ns / 1ps

module mrrc_frame_core
	import mrrc_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 255,
	parameter int MAX_WORDS       = 125,
	parameter int CNT_W           = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic [7:0] rx_byte,
	input  logic       frame_last,
	input  logic       advance,
	output logic       has_res,
	output res_t       res
);

	`include "modbus_read_reply_checker_top_assert.svh"

	logic [CNT_W-1:0] byte_cnt_q;
	logic [6:0]       word_cnt_q;
	logic [15:0]      crc_q;
	logic [15:0]      delayed_q;
	logic [7:0]       address_q;
	logic [7:0]       fcode_q;
	logic [7:0]       third_q;
	logic [7:0]       pending_q;

	logic             live;
	logic             count_ok;
	logic             word_fire;
	logic             at_high;
	logic [15:0]      crc_next;
	logic [15:0]      delayed_next;
	logic [CNT_W-1:0] length;
	frame_view_t      view;
	logic [2:0]       status;
	logic [7:0]       exc_code;

	// byte position decode
	assign live     = byte_cnt_q <= CNT_W'(MAX_FRAME_BYTES);
	assign count_ok = (cfg.wcount != 7'd0) && (cfg.wcount <= 7'(MAX_WORDS));
	assign at_high  = live && (byte_cnt_q > CNT_W'(2)) && byte_cnt_q[0];
	assign word_fire = live && (byte_cnt_q > CNT_W'(2)) && !byte_cnt_q[0] &&
		!frame_last && count_ok && (word_cnt_q < cfg.wcount);
	assign has_res  = word_fire || frame_last;

	// crc lags two bytes behind so the trailer stays out of it
	assign crc_next     = (byte_cnt_q >= CNT_W'(2)) ? crc_feed(crc_q, delayed_q[15:8]) : crc_q;
	assign delayed_next = {delayed_q[7:0], rx_byte};
	assign length       = live ? (byte_cnt_q + CNT_W'(1)) : byte_cnt_q;

	assign view = '{address: address_q, fcode: fcode_q, third: third_q,
		crc: crc_next, delayed: delayed_next};

	mrrc_status_eval #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES),
		.MAX_WORDS(MAX_WORDS),
		.CNT_W(CNT_W)
	) u_status (
		.cfg(cfg),
		.view(view),
		.length(length),
		.status(status),
		.exc_code(exc_code)
	);

	// result selection
	always_comb begin
		if (frame_last) begin
			res = '{kind: KIND_STATUS, word_index: 7'd0, word_value: 16'd0,
				status: status, exc_code: exc_code};
		end else begin
			res = '{kind: KIND_WORD, word_index: word_cnt_q,
				word_value: {pending_q, rx_byte}, status: ST_OK, exc_code: 8'd0};
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			word_cnt_q <= 7'd0;
			crc_q      <= CRC_INIT;
			delayed_q  <= 16'd0;
			address_q  <= 8'd0;
			fcode_q    <= 8'd0;
			third_q    <= 8'd0;
			pending_q  <= 8'd0;
		end else if (advance) begin
			delayed_q <= delayed_next;
			if (live && byte_cnt_q == CNT_W'(0)) begin
				address_q <= rx_byte;
			end
			if (live && byte_cnt_q == CNT_W'(1)) begin
				fcode_q <= rx_byte;
			end
			if (live && byte_cnt_q == CNT_W'(2)) begin
				third_q <= rx_byte;
			end
			if (at_high) begin
				pending_q <= rx_byte;
			end
			if (frame_last) begin
				byte_cnt_q <= '0;
				word_cnt_q <= 7'd0;
				crc_q      <= CRC_INIT;
			end else begin
				crc_q <= crc_next;
				if (live) begin
					byte_cnt_q <= byte_cnt_q + CNT_W'(1);
				end
				if (word_fire) begin
					word_cnt_q <= word_cnt_q + 7'd1;
				end
			end
		end
	end

	`MRRC_ASSERT_CLK(a_cnt_saturates, clk, arst_n, byte_cnt_q <= CNT_W'(MAX_FRAME_BYTES + 1), "byte counter beyond saturation")
	`MRRC_ASSERT_NEXT(a_frame_restart, clk, arst_n, advance && frame_last, byte_cnt_q == '0 && word_cnt_q == 7'd0 && crc_q == CRC_INIT, "frame state not restored after last byte")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import mrrc_pkg::*;

	localparam int FRAME_MAX = 255;
	localparam int WORDS_MAX = 125;

	// read function codes and the index that maps to no register
	localparam logic [2:0] FN_HOLDING = 3'd3;
	localparam logic [2:0] FN_INPUT   = 3'd4;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         hold;
	} reply_byte_t;

	typedef enum int {
		FR_GOOD, FR_BAD_CRC, FR_BAD_SLAVE, FR_EXCEPTION, FR_EXC_LONG,
		FR_BAD_FUNC, FR_BAD_COUNT, FR_BAD_LEN, FR_SHORT, FR_NOISE
	} frame_shape_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [7:0] cfg_data;

	mrrc_in_if  in_ch();
	mrrc_out_if out_ch();

	modbus_read_reply_checker_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// expected configuration
	logic [7:0] cfg_slave;
	logic [2:0] cfg_fcode;
	logic [6:0] cfg_wcount;

	// expected frame state
	logic [8:0]  rx_pos;
	logic [15:0] crc_run;
	logic [15:0] tail_bytes;
	logic [7:0]  hdr_addr;
	logic [7:0]  hdr_fcode;
	logic [7:0]  hdr_third;
	logic [7:0]  word_hi;
	logic [6:0]  words_out;

	reply_byte_t pending[$];
	res_t        reply_expect[$];
	reply_byte_t nxt;
	res_t        want;
	int          queued_bytes;
	int          errs;
	int          send_gap;
	int          take_gap;
	int          bytes_seen;
	int          long_hold_left;
	bit          idling;
	bit          calm;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// crc-16/modbus, reflected, one byte
	function automatic logic [15:0] crc16_shift(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {8'h00, b};
		repeat (8) c = c[0] ? ({1'b0, c[15:1]} ^ CRC_POLY) : {1'b0, c[15:1]};
		return c;
	endfunction

	function automatic bit count_legal();
		return cfg_wcount >= 1 && cfg_wcount <= WORDS_MAX;
	endfunction

	// end-of-frame verdict, checks in priority order
	function automatic logic [2:0] frame_verdict(input int len, output logic [7:0] code);
		code = '0;
		if (len < MIN_FRAME || len > FRAME_MAX || !count_legal())
			return ST_MALFORMED;
		if (tail_bytes[15:8] != crc_run[7:0] || tail_bytes[7:0] != crc_run[15:8])
			return ST_CRC;
		if (hdr_addr != cfg_slave)
			return ST_SLAVE;
		if (hdr_fcode == ({5'b0, cfg_fcode} | EXC_FLAG)) begin
			if (len == MIN_FRAME) begin
				code = hdr_third;
				return ST_EXCEPTION;
			end
			return ST_MALFORMED;
		end
		if (hdr_fcode != {5'b0, cfg_fcode})
			return ST_FUNCTION;
		if (hdr_third != {cfg_wcount, 1'b0})
			return ST_BYTECOUNT;
		if (len != 2 * cfg_wcount + HEADER_LEN)
			return ST_MALFORMED;
		return ST_OK;
	endfunction

	// advance the expected state by one accepted byte
	function automatic void predict_reply_byte(input logic [7:0] b, input logic last);
		logic [8:0] pos;
		bit         live;
		int         len;
		res_t       r;
		pos = rx_pos;
		live = pos <= FRAME_MAX;
		r = '0;
		if (pos >= 2)
			crc_run = crc16_shift(crc_run, tail_bytes[15:8]);
		tail_bytes = {tail_bytes[7:0], b};
		if (live) begin
			if (pos == 0)
				hdr_addr = b;
			else if (pos == 1)
				hdr_fcode = b;
			else if (pos == 2)
				hdr_third = b;
			else if (pos[0])
				word_hi = b;
			else if (!last && count_legal() && words_out < cfg_wcount) begin
				r.kind = KIND_WORD;
				r.word_index = words_out;
				r.word_value = {word_hi, b};
				reply_expect.insert(reply_expect.size(), r);
				words_out++;
			end
			rx_pos = pos + 9'd1;
		end
		if (last) begin
			len = live ? int'(pos) + 1 : int'(pos);
			r = '0;
			r.kind = KIND_STATUS;
			r.status = frame_verdict(len, r.exc_code);
			reply_expect.insert(reply_expect.size(), r);
			rx_pos = '0;
			words_out = '0;
			crc_run = CRC_INIT;
		end
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] got);
		if (got !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got);
			errs++;
		end
	endfunction

	// append the crc, low byte first
	function automatic void seal(ref byte_q_t f);
		logic [15:0] c;
		c = CRC_INIT;
		foreach (f[i]) c = crc16_shift(c, f[i]);
		f.insert(f.size(), c[7:0]);
		f.insert(f.size(), c[15:8]);
	endfunction

	// build a reply frame of the given shape for the current configuration
	function automatic byte_q_t make_frame(input frame_shape_t shape);
		byte_q_t    f;
		int         n;
		int         d;
		logic [7:0] x;
		f = {};
		case (shape)
		FR_SHORT, FR_NOISE: begin
			n = (shape == FR_SHORT) ? $urandom_range(1, 4) : $urandom_range(1, 20);
			repeat (n) f.insert(f.size(), 8'($urandom));
		end
		FR_EXCEPTION, FR_EXC_LONG: begin
			f.insert(f.size(), cfg_slave);
			f.insert(f.size(), {5'b0, cfg_fcode} | EXC_FLAG);
			f.insert(f.size(), 8'($urandom));
			if (shape == FR_EXC_LONG)
				repeat ($urandom_range(1, 4)) f.insert(f.size(), 8'($urandom));
			seal(f);
		end
		default: begin
			x = cfg_slave;
			if (shape == FR_BAD_SLAVE)
				x = x ^ 8'($urandom_range(1, 255));
			f.insert(f.size(), x);
			// flipping only low bits keeps clear of the exception code
			x = {5'b0, cfg_fcode};
			if (shape == FR_BAD_FUNC)
				x = x ^ 8'($urandom_range(1, 127));
			f.insert(f.size(), x);
			n = 2 * cfg_wcount;
			x = 8'(n);
			if (shape == FR_BAD_COUNT)
				x = x ^ 8'($urandom_range(1, 255));
			f.insert(f.size(), x);
			if (shape == FR_BAD_LEN) begin
				d = $urandom_range(0, 4);
				n = n + ((d < 2) ? d - 2 : d - 1);
			end
			repeat (n) f.insert(f.size(), 8'($urandom));
			seal(f);
			if (shape == FR_BAD_CRC)
				f[f.size() - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
		end
		endcase
		return f;
	endfunction

	// hand a frame to the driver, optionally pausing somewhere inside it
	function automatic void queue_frame(input byte_q_t f, input bit pause_mid);
		reply_byte_t it;
		int          at;
		at = (pause_mid && f.size() > 1) ? $urandom_range(1, f.size() - 1) : -1;
		foreach (f[i]) begin
			it.data = f[i];
			it.last = (i == f.size() - 1);
			it.hold = (i == at);
			pending.insert(pending.size(), it);
		end
		queued_bytes += f.size();
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
		REG_SLAVE: cfg_slave = val;
		REG_FUNCTION: cfg_fcode = val[2:0];
		REG_WCOUNT: cfg_wcount = val[6:0];
		default: ;
		endcase
	endtask

	task automatic configure(input logic [7:0] s, input logic [7:0] fd, input logic [7:0] wd);
		write_reg(REG_SLAVE, s);
		write_reg(REG_FUNCTION, fd);
		write_reg(REG_WCOUNT, wd);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every byte is in and every result is out
	task automatic drain();
		do
			@(posedge clk);
		while (pending.size() != 0 || in_ch.valid || reply_expect.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_phase();
		int         r;
		logic [7:0] s;
		logic [7:0] fd;
		logic [7:0] wd;
		drain();
		r = $urandom_range(0, 9);
		s = (r == 0) ? 8'd1 : (r == 1) ? 8'd254 : (r == 2) ? 8'd0 : (r == 3) ? 8'd255 :
			8'($urandom_range(1, 254));
		fd = 8'($urandom);
		if ($urandom_range(0, 9) == 0)
			fd[2:0] = 3'($urandom);
		else
			fd[2:0] = $urandom_range(0, 1) ? FN_HOLDING : FN_INPUT;
		wd = 8'($urandom);
		wd[6:0] = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(7, 16)) :
			7'($urandom_range(1, 6));
		configure(s, fd, wd);
		idling <= !calm && $urandom_range(0, 3) != 0;
		repeat ($urandom_range(2, 5)) begin
			r = $urandom_range(0, 18);
			queue_frame(make_frame((r < 10) ? FR_GOOD : frame_shape_t'(r - 9)),
				$urandom_range(0, 5) == 0);
		end
	endtask

	// byte driver, predicts each accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.rx_byte <= '0;
			in_ch.frame_last <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				predict_reply_byte(in_ch.rx_byte, in_ch.frame_last);
			if (!in_ch.valid || in_ch.ready) begin
				if (in_ch.valid && idling && long_hold_left == 0 && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 15);
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending.size() != 0 &&
					!(pending[0].hold && reply_expect.size() != 0)) begin
					nxt = pending.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.rx_byte <= nxt.data;
					in_ch.frame_last <= nxt.last;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off at two points in the run
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen <= 0;
			long_hold_left <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				bytes_seen <= bytes_seen + 1;
			if (long_hold_left != 0)
				long_hold_left <= long_hold_left - 1;
			else if (!calm && in_ch.valid && in_ch.ready &&
				(bytes_seen == 120 || bytes_seen == 450))
				long_hold_left <= 300;
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			take_gap = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (reply_expect.size() == 0) begin
					$error("result_kind %0d arrived with nothing predicted", out_ch.result_kind);
					errs++;
				end else begin
					want = reply_expect.pop_front();
					check_field("result_kind", 16'(want.kind), 16'(out_ch.result_kind));
					check_field("word_index", 16'(want.word_index), 16'(out_ch.word_index));
					check_field("word_value", want.word_value, out_ch.word_value);
					check_field("status", 16'(want.status), 16'(out_ch.status));
					check_field("exc_code", 16'(want.exc_code), 16'(out_ch.exc_code));
				end
			end
			if (take_gap == 0 && idling && $urandom_range(0, 11) == 0)
				take_gap = $urandom_range(1, 15);
			if (long_hold_left != 0) begin
				out_ch.ready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// stimulus sequence
	initial begin
		byte_q_t    f;
		logic [7:0] fc8;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		cfg_slave = 8'd1;
		cfg_fcode = FN_HOLDING;
		cfg_wcount = 7'd1;
		rx_pos = '0;
		crc_run = CRC_INIT;
		tail_bytes = '0;
		hdr_addr = '0;
		hdr_fcode = '0;
		hdr_third = '0;
		word_hi = '0;
		words_out = '0;
		queued_bytes = 0;
		errs = 0;
		idling = 1'b1;
		calm = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames under the reset configuration
		fc8 = {5'b0, cfg_fcode};
		f = '{cfg_slave, fc8, 8'h02, 8'hFF, 8'h00};
		seal(f);
		queue_frame(f, 1'b1);
		f = '{cfg_slave, fc8 | EXC_FLAG, 8'hFF};
		seal(f);
		queue_frame(f, 1'b0);
		// single byte frame, then a four byte one
		f = '{8'h00};
		queue_frame(f, 1'b0);
		f = '{cfg_slave, fc8, 8'h00, 8'hFF};
		queue_frame(f, 1'b0);
		f = '{cfg_slave, fc8, 8'h02, 8'h00, 8'hFF};
		seal(f);
		f[f.size() - 1] ^= 8'h80;
		queue_frame(f, 1'b0);

		while (queued_bytes < 30)
			random_phase();

		// largest legal reply
		drain();
		configure(8'd254, {5'b11111, FN_INPUT}, 8'd125);
		queue_frame(make_frame(FR_GOOD), 1'b0);
		queue_frame(make_frame(FR_EXCEPTION), 1'b0);

		// word count above the limit, reply runs past the byte counter
		drain();
		write_reg(REG_UNUSED, 8'($urandom));
		configure(8'd0, {5'b0, FN_HOLDING}, 8'hFF);
		queue_frame(make_frame(FR_GOOD), 1'b0);
		queue_frame(make_frame(FR_SHORT), 1'b0);

		// word count of zero
		drain();
		configure(8'd255, 8'h07, 8'h80);
		queue_frame(make_frame(FR_GOOD), 1'b0);
		queue_frame(make_frame(FR_EXCEPTION), 1'b0);

		// closing stretch without idling
		calm <= 1'b1;
		idling <= 1'b0;
		while (queued_bytes < 620)
			random_phase();

		drain();
		repeat (10) @(posedge clk);
		if (errs == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
